### rtl/cycle_graph_transposition_engine_top_assert.svh
// Assertion helpers for the cycle graph engine.
`ifndef CYCLE_GRAPH_TRANSPOSITION_ENGINE_TOP_ASSERT_SVH
`define CYCLE_GRAPH_TRANSPOSITION_ENGINE_TOP_ASSERT_SVH

// Condition that holds at every clock edge out of reset.
`define CGTE_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("cgte: invariant failed");

// Antecedent implies consequent in the following cycle.
`define CGTE_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cgte: sequence check failed");

`endif

### rtl/cgte_pkg.sv
package cgte_pkg;

	localparam int CAPACITY    = 512;
	localparam int ADDR_W      = $clog2(CAPACITY);
	localparam int LINK_W      = 10;
	localparam int CYCLE_LIMIT = 3;
	localparam int PAIR_SIZE   = 2;

	localparam logic [LINK_W-1:0] END_MARK = '1;
	localparam logic [LINK_W-1:0] CAP_L    = LINK_W'(CAPACITY);

	typedef enum logic [2:0] {
		CMD_LOAD      = 3'd0,
		CMD_TRANSPOSE = 3'd1,
		CMD_SIMPLIFY  = 3'd2,
		CMD_CONVERT   = 3'd3,
		CMD_READ      = 3'd4,
		CMD_QUERY     = 3'd5
	} cmd_e_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_CAP   = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [8:0] value;
		logic       last;
		logic [8:0] idx_a;
		logic [8:0] idx_b;
		logic [8:0] idx_c;
	} cmd_req_t;

	typedef struct packed {
		logic [9:0] result_value;
		logic [9:0] prev_value;
		logic [9:0] node_count;
		logic [1:0] status;
	} cmd_rsp_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_GRAY,
		S_TR1, S_TR2, S_TR3, S_TR4, S_TR5,
		S_RD1, S_Q1, S_Q2,
		S_G1, S_G2, S_P1, S_P2,
		S_F0, S_F1, S_F2, S_F3,
		S_CLR, S_TOP, S_MK, S_W1, S_W2, S_W3, S_EV,
		S_SP0, S_SP1, S_SP2,
		S_DONE
	} state_t;

endpackage

### rtl/cgte_ram.sv
module cgte_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/cycle_graph_transposition_engine_top.sv
// Cycle graph engine: holds a framed permutation as black and gray link tables
// in RAMs with one read and one write port each, and runs each command under
// one sequencer, one command at a time. The final load element also sweeps
// the gray table. Convert walks the gray chain to label vertices, then the
// black chain to write the permutation. Simplify first clears the mark table,
// then follows the links from each unmarked vertex and splits cycles that do
// not close within the cycle limit, then runs convert and a refill of the
// black and gray tables. Results are registered; a new command is taken while
// the previous result still waits.
module cycle_graph_transposition_engine_top
	import cgte_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_stall,
	input  cmd_req_t cmd_data,
	output logic     res_valid,
	input  logic     res_stall,
	output cmd_rsp_t res_data
);

	`include "cycle_graph_transposition_engine_top_assert.svh"

	localparam logic [1:0] CNT_LAST = 2'(CYCLE_LIMIT - 1);

	state_t state_q, state_d;

	cmd_req_t          req_q;
	logic [LINK_W-1:0] n_q, pos_q, lprev_q, i_q, v_q, w_q, t_q, gr_q, steps_q;
	logic [1:0]        cnt_q;
	logic              simp_q;
	logic [LINK_W-1:0] res_val_q, prev_val_q;
	status_t           status_q;
	cmd_rsp_t          out_q;
	logic              out_valid_q;

	logic              blk_we, gry_we, lab_we, prm_we, mk_we;
	logic [ADDR_W-1:0] blk_wa, gry_wa, lab_wa, prm_wa, mk_wa;
	logic [ADDR_W-1:0] blk_ra, gry_ra, lab_ra, prm_ra, mk_ra;
	logic [LINK_W-1:0] blk_wd, gry_wd, lab_wd, prm_wd;
	logic [LINK_W-1:0] blk_rd, gry_rd, lab_rd, prm_rd;
	logic              mk_wd, mk_rd;

	logic              accept, slot_free;
	logic              a_ok, b_ok, c_ok, v_lt, i_lt, steps_lt;
	logic              blk_lt, gry_lt, prm_lt, w_cont, cap_over;
	logic [LINK_W:0]   n_plus2;
	logic [LINK_W-1:0] i_next, prm_pos;

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign slot_free = !out_valid_q || !res_stall;
	assign res_valid = out_valid_q;
	assign res_data  = out_q;

	assign a_ok     = {1'b0, req_q.idx_a} < n_q;
	assign b_ok     = {1'b0, req_q.idx_b} < n_q;
	assign c_ok     = {1'b0, req_q.idx_c} < n_q;
	assign v_lt     = v_q < n_q;
	assign i_lt     = i_q < n_q;
	assign steps_lt = steps_q < n_q;
	assign blk_lt   = blk_rd < n_q;
	assign gry_lt   = gry_rd < n_q;
	assign prm_lt   = prm_rd < n_q;
	assign w_cont   = (gry_rd != v_q) && (cnt_q < CNT_LAST);
	assign n_plus2  = {1'b0, n_q} + (LINK_W+1)'(PAIR_SIZE);
	assign cap_over = n_plus2 > (LINK_W+1)'(CAPACITY);
	assign i_next   = i_q + 1'b1;
	assign prm_pos  = n_q - 1'b1 - steps_q;

	cgte_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_blk (
		.clk(clk), .we(blk_we), .waddr(blk_wa), .wdata(blk_wd), .raddr(blk_ra), .rdata(blk_rd)
	);
	cgte_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_gry (
		.clk(clk), .we(gry_we), .waddr(gry_wa), .wdata(gry_wd), .raddr(gry_ra), .rdata(gry_rd)
	);
	cgte_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_lab (
		.clk(clk), .we(lab_we), .waddr(lab_wa), .wdata(lab_wd), .raddr(lab_ra), .rdata(lab_rd)
	);
	cgte_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_prm (
		.clk(clk), .we(prm_we), .waddr(prm_wa), .wdata(prm_wd), .raddr(prm_ra), .rdata(prm_rd)
	);
	cgte_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_mk (
		.clk(clk), .we(mk_we), .waddr(mk_wa), .wdata(mk_wd), .raddr(mk_ra), .rdata(mk_rd)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (accept) state_d = S_DISP;
			S_DISP: begin
				unique case (req_q.cmd)
					CMD_LOAD: begin
						if (pos_q >= CAP_L || {1'b0, req_q.value} >= CAP_L) state_d = S_DONE;
						else if (req_q.last) state_d = S_GRAY;
						else state_d = S_DONE;
					end
					CMD_TRANSPOSE: state_d = (a_ok && b_ok && c_ok) ? S_TR1 : S_DONE;
					CMD_SIMPLIFY:  state_d = (n_q == '0) ? S_DONE : S_CLR;
					CMD_CONVERT:   state_d = S_G1;
					CMD_READ:      state_d = a_ok ? S_RD1 : S_DONE;
					CMD_QUERY:     state_d = a_ok ? S_Q1 : S_DONE;
					default:       state_d = S_DONE;
				endcase
			end
			S_GRAY: if (i_next == n_q) state_d = S_DONE;
			S_TR1:  state_d = S_TR2;
			S_TR2:  state_d = S_TR3;
			S_TR3:  state_d = S_TR4;
			S_TR4:  state_d = S_TR5;
			S_TR5:  state_d = S_DONE;
			S_RD1:  state_d = S_DONE;
			S_Q1:   state_d = blk_lt ? S_Q2 : S_DONE;
			S_Q2:   state_d = S_DONE;
			S_G1: begin
				priority if (v_lt && i_lt) state_d = S_G2;
				else if (i_q == '0) state_d = S_DONE;
				else state_d = S_P1;
			end
			S_G2:   state_d = S_G1;
			S_P1: begin
				priority if (v_lt && steps_lt) state_d = S_P2;
				else if (simp_q) state_d = S_F0;
				else state_d = S_DONE;
			end
			S_P2:   state_d = S_P1;
			S_F0:   state_d = S_F1;
			S_F1:   state_d = S_F2;
			S_F2:   state_d = i_lt ? S_F3 : S_GRAY;
			S_F3:   state_d = S_F2;
			S_CLR:  if (i_q == LINK_W'(CAPACITY - 1)) state_d = S_TOP;
			S_TOP:  state_d = (v_q == '0) ? S_G1 : S_MK;
			S_MK:   state_d = mk_rd ? S_TOP : S_W1;
			S_W1:   state_d = S_W2;
			S_W2:   state_d = blk_lt ? S_W3 : S_DONE;
			S_W3: begin
				priority if (!gry_lt) state_d = S_DONE;
				else if (w_cont) state_d = S_W1;
				else state_d = S_EV;
			end
			S_EV: begin
				priority if (w_q == v_q) state_d = S_TOP;
				else if (cap_over) state_d = S_DONE;
				else state_d = S_SP0;
			end
			S_SP0:  state_d = S_SP1;
			S_SP1:  state_d = S_SP2;
			S_SP2:  state_d = S_TOP;
			S_DONE: if (slot_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// table port control
	always_comb begin
		blk_we = 1'b0; blk_wa = '0; blk_wd = '0; blk_ra = '0;
		gry_we = 1'b0; gry_wa = '0; gry_wd = '0; gry_ra = '0;
		lab_we = 1'b0; lab_wa = '0; lab_wd = '0; lab_ra = '0;
		prm_we = 1'b0; prm_wa = '0; prm_wd = '0; prm_ra = '0;
		mk_we  = 1'b0; mk_wa  = '0; mk_wd  = 1'b0; mk_ra = '0;
		unique case (state_q)
			S_DISP: begin
				unique case (req_q.cmd)
					CMD_LOAD: begin
						if (pos_q < CAP_L && {1'b0, req_q.value} < CAP_L) begin
							blk_we = 1'b1;
							blk_wa = (pos_q == '0) ? '0 : req_q.value;
							blk_wd = (pos_q == '0) ? END_MARK : lprev_q;
							prm_we = 1'b1;
							prm_wa = pos_q[ADDR_W-1:0];
							prm_wd = {1'b0, req_q.value};
						end
					end
					CMD_TRANSPOSE: blk_ra = req_q.idx_b;
					CMD_READ:      prm_ra = req_q.idx_a;
					CMD_QUERY:     blk_ra = req_q.idx_a;
					default: ;
				endcase
			end
			S_GRAY: begin
				gry_we = 1'b1;
				gry_wa = i_q[ADDR_W-1:0];
				gry_wd = (i_next < n_q) ? i_next : END_MARK;
			end
			S_TR1: blk_ra = req_q.idx_a;
			S_TR2: begin
				blk_we = 1'b1; blk_wa = req_q.idx_b; blk_wd = blk_rd;
			end
			S_TR3: blk_ra = req_q.idx_c;
			S_TR4: begin
				blk_we = 1'b1; blk_wa = req_q.idx_a; blk_wd = blk_rd;
			end
			S_TR5: begin
				blk_we = 1'b1; blk_wa = req_q.idx_c; blk_wd = t_q;
			end
			S_Q1: gry_ra = blk_rd[ADDR_W-1:0];
			S_G1: begin
				gry_ra = v_q[ADDR_W-1:0];
				if (v_lt && i_lt) begin
					lab_we = 1'b1; lab_wa = v_q[ADDR_W-1:0]; lab_wd = i_q;
				end
			end
			S_P1: begin
				lab_ra = v_q[ADDR_W-1:0];
				blk_ra = v_q[ADDR_W-1:0];
			end
			S_P2: begin
				prm_we = 1'b1; prm_wa = prm_pos[ADDR_W-1:0]; prm_wd = lab_rd;
			end
			S_F0: begin
				blk_we = 1'b1; blk_wa = '0; blk_wd = END_MARK;
				prm_ra = '0;
			end
			S_F2: prm_ra = i_q[ADDR_W-1:0];
			S_F3: begin
				blk_we = prm_lt; blk_wa = prm_rd[ADDR_W-1:0]; blk_wd = t_q;
			end
			S_CLR: begin
				mk_we = 1'b1; mk_wa = i_q[ADDR_W-1:0];
			end
			S_TOP: mk_ra = v_q[ADDR_W-1:0];
			S_W1:  blk_ra = w_q[ADDR_W-1:0];
			S_W2:  gry_ra = blk_rd[ADDR_W-1:0];
			S_W3: begin
				mk_we = gry_lt; mk_wa = gry_rd[ADDR_W-1:0]; mk_wd = 1'b1;
			end
			S_EV: begin
				mk_we = (w_q != v_q); mk_wa = w_q[ADDR_W-1:0];
			end
			S_SP0: begin
				blk_ra = v_q[ADDR_W-1:0];
				gry_ra = gr_q[ADDR_W-1:0];
				blk_we = 1'b1; blk_wa = n_q[ADDR_W-1:0]; blk_wd = n_q + 1'b1;
				gry_we = 1'b1; gry_wa = n_plus2[ADDR_W-1:0] - 1'b1; gry_wd = n_q;
			end
			S_SP1: begin
				blk_we = 1'b1; blk_wa = n_plus2[ADDR_W-1:0] - 1'b1; blk_wd = blk_rd;
				gry_we = 1'b1; gry_wa = n_q[ADDR_W-1:0]; gry_wd = gry_rd;
			end
			S_SP2: begin
				blk_we = 1'b1; blk_wa = v_q[ADDR_W-1:0]; blk_wd = n_q;
				gry_we = 1'b1; gry_wa = gr_q[ADDR_W-1:0]; gry_wd = n_q + 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= '0;
			pos_q       <= '0;
			lprev_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && slot_free) out_valid_q <= 1'b1;
			else if (!res_stall) out_valid_q <= 1'b0;
			if (state_q == S_DISP && req_q.cmd == CMD_LOAD && pos_q < CAP_L
					&& {1'b0, req_q.value} < CAP_L) begin
				lprev_q <= {1'b0, req_q.value};
				if (req_q.last) begin
					n_q   <= pos_q + 1'b1;
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
			if (state_q == S_SP2) n_q <= n_plus2[LINK_W-1:0];
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (accept) begin
				req_q      <= cmd_data;
				res_val_q  <= '0;
				prev_val_q <= '0;
				status_q   <= STAT_OK;
			end
			S_DISP: begin
				i_q <= '0;
				unique case (req_q.cmd)
					CMD_LOAD: begin
						if (pos_q >= CAP_L) status_q <= STAT_CAP;
						else if ({1'b0, req_q.value} >= CAP_L) status_q <= STAT_RANGE;
					end
					CMD_TRANSPOSE, CMD_READ, CMD_QUERY: begin
						if (!(a_ok && (req_q.cmd != CMD_TRANSPOSE || (b_ok && c_ok))))
							status_q <= STAT_RANGE;
					end
					CMD_SIMPLIFY: simp_q <= 1'b1;
					CMD_CONVERT: begin
						simp_q <= 1'b0;
						v_q    <= '0;
					end
					default: ;
				endcase
			end
			S_GRAY: i_q <= i_next;
			S_TR1:  t_q <= blk_rd;
			S_RD1:  res_val_q <= prm_rd;
			S_Q1: begin
				prev_val_q <= blk_rd;
				if (!blk_lt) res_val_q <= END_MARK;
			end
			S_Q2: res_val_q <= gry_rd;
			S_G1: begin
				if (v_lt && i_lt) begin
					w_q <= v_q;
					i_q <= i_next;
				end else begin
					v_q     <= w_q;
					steps_q <= '0;
				end
			end
			S_G2: v_q <= gry_rd;
			S_P2: begin
				v_q     <= blk_rd;
				steps_q <= steps_q + 1'b1;
			end
			S_F0: i_q <= LINK_W'(1);
			S_F1: t_q <= prm_rd;
			S_F2: if (!i_lt) i_q <= '0;
			S_F3: begin
				t_q <= prm_rd;
				i_q <= i_next;
			end
			S_CLR: begin
				i_q <= i_next;
				v_q <= n_q - 1'b1;
			end
			S_TOP: begin
				w_q <= '0;
				i_q <= '0;
			end
			S_MK: begin
				if (mk_rd) begin
					v_q <= v_q - 1'b1;
				end else begin
					w_q   <= v_q;
					cnt_q <= '0;
				end
			end
			S_W2: begin
				gr_q <= blk_rd;
				if (!blk_lt) status_q <= STAT_RANGE;
			end
			S_W3: begin
				w_q   <= gry_rd;
				cnt_q <= cnt_q + 1'b1;
				if (!gry_lt) status_q <= STAT_RANGE;
			end
			S_EV: if (w_q != v_q && cap_over) status_q <= STAT_CAP;
			S_DONE: if (slot_free) begin
				out_q.result_value <= res_val_q;
				out_q.prev_value   <= prev_val_q;
				out_q.node_count   <= n_q;
				out_q.status       <= status_q;
			end
			default: ;
		endcase
	end

	`CGTE_ALWAYS(a_count_cap, n_q <= CAP_L)
	`CGTE_ALWAYS(a_pos_cap, pos_q <= CAP_L)
	`CGTE_NEXT(a_accept_leaves_idle, accept, state_q == S_DISP)
	`CGTE_NEXT(a_done_delivers, state_q == S_DONE && slot_free, res_valid && state_q == S_IDLE)

endmodule

### verif/cycle_graph_transposition_engine_top_test.sv
module cycle_graph_transposition_engine_top_test;
	import cgte_pkg::*;

	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;

	logic     clk;
	logic     arst_n;
	logic     cmd_valid;
	logic     cmd_stall;
	cmd_req_t cmd_data;
	logic     res_valid;
	logic     res_stall;
	cmd_rsp_t res_data;

	cycle_graph_transposition_engine_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_data(cmd_data),
		.res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// graph mirror
	logic [9:0]  blk [CAPACITY];
	logic [9:0]  gry [CAPACITY];
	logic [9:0]  labs [CAPACITY];
	logic [9:0]  prm [CAPACITY];
	bit          marks [CAPACITY];
	bit          blk_w [CAPACITY];
	bit          gry_w [CAPACITY];
	bit          prm_w [CAPACITY];
	int unsigned nv, lpos, lprev;
	bit          unwritten_rd;

	logic [9:0]  s_blk [CAPACITY];
	logic [9:0]  s_gry [CAPACITY];
	logic [9:0]  s_labs [CAPACITY];
	logic [9:0]  s_prm [CAPACITY];
	bit          s_blk_w [CAPACITY];
	bit          s_gry_w [CAPACITY];
	bit          s_prm_w [CAPACITY];
	int unsigned s_nv, s_lpos, s_lprev;

	cmd_rsp_t    rsp_q [$];
	int          errors, n_items, n_results, n_ranges, n_caps;
	int          s_idle, r_idle;

	task automatic report(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic logic [9:0] rd_blk(int unsigned i);
		if (!blk_w[i]) unwritten_rd = 1'b1;
		return blk[i];
	endfunction

	function automatic logic [9:0] rd_gry(int unsigned i);
		if (!gry_w[i]) unwritten_rd = 1'b1;
		return gry[i];
	endfunction

	function automatic logic [9:0] rd_prm(int unsigned i);
		if (!prm_w[i]) unwritten_rd = 1'b1;
		return prm[i];
	endfunction

	function automatic void set_blk(int unsigned i, logic [9:0] d);
		blk[i] = d;
		blk_w[i] = 1'b1;
	endfunction

	function automatic void set_gry(int unsigned i, logic [9:0] d);
		gry[i] = d;
		gry_w[i] = 1'b1;
	endfunction

	function automatic void chain_grays(int unsigned n);
		for (int unsigned i = 0; i + 1 < n; i++) set_gry(i, 10'(i + 1));
		if (n > 0) set_gry(n - 1, END_MARK);
	endfunction

	function automatic void graph_to_perm();
		int unsigned v, w, i;
		bit any;
		v = 0; w = 0; i = 0; any = 1'b0;
		while (v < nv && i < nv) begin
			labs[v] = 10'(i);
			i++;
			w = v;
			any = 1'b1;
			v = rd_gry(v);
		end
		if (!any) return;
		v = w;
		for (int unsigned st = 0; v < nv && st < nv; st++) begin
			prm[nv - 1 - st] = labs[v];
			prm_w[nv - 1 - st] = 1'b1;
			v = rd_blk(v);
		end
	endfunction

	function automatic void perm_to_graph();
		int unsigned t;
		if (nv == 0) return;
		set_blk(0, END_MARK);
		for (int unsigned i = 1; i < nv; i++) begin
			t = rd_prm(i);
			if (t < nv) set_blk(t, rd_prm(i - 1));
		end
		chain_grays(nv);
	endfunction

	function automatic status_t simplify_graph();
		int unsigned v, w, gr, cnt, nb, ng;
		if (nv == 0) return STAT_OK;
		foreach (marks[i]) marks[i] = 1'b0;
		v = nv - 1;
		while (v != 0) begin
			if (marks[v]) begin
				v--;
				continue;
			end
			cnt = 0;
			w = v;
			gr = 0;
			do begin
				gr = rd_blk(w);
				if (gr >= nv) return STAT_RANGE;
				w = rd_gry(gr);
				if (w >= nv) return STAT_RANGE;
				marks[w] = 1'b1;
				cnt++;
			end while (w != v && cnt < CYCLE_LIMIT);
			if (w != v) begin
				marks[w] = 1'b0;
				if (nv + PAIR_SIZE > CAPACITY) return STAT_CAP;
				// insert a vertex pair: new black nb->ng, gray ng->nb
				nb = nv;
				ng = nv + 1;
				nv += PAIR_SIZE;
				set_blk(nb, 10'(ng));
				set_gry(ng, 10'(nb));
				set_blk(ng, rd_blk(v));
				set_blk(v, 10'(nb));
				set_gry(nb, rd_gry(gr));
				set_gry(gr, 10'(ng));
			end
		end
		graph_to_perm();
		perm_to_graph();
		return STAT_OK;
	endfunction

	function automatic cmd_rsp_t engine_step(cmd_req_t rq);
		cmd_rsp_t rs;
		logic [9:0] t, p;
		status_t st;
		int unsigned a, b, c;
		rs = '0;
		st = STAT_OK;
		a = rq.idx_a; b = rq.idx_b; c = rq.idx_c;
		case (rq.cmd)
			CMD_LOAD: begin
				if (lpos >= CAPACITY) st = STAT_CAP;
				else if (rq.value >= CAPACITY) st = STAT_RANGE;
				else begin
					if (lpos == 0) set_blk(0, END_MARK);
					else set_blk(rq.value, 10'(lprev));
					prm[lpos] = 10'(rq.value);
					prm_w[lpos] = 1'b1;
					lprev = rq.value;
					if (rq.last) begin
						nv = lpos + 1;
						chain_grays(nv);
						lpos = 0;
					end else begin
						lpos++;
					end
				end
			end
			CMD_TRANSPOSE: begin
				if (a >= nv || b >= nv || c >= nv) st = STAT_RANGE;
				else begin
					t = rd_blk(b);
					set_blk(b, rd_blk(a));
					set_blk(a, rd_blk(c));
					set_blk(c, t);
				end
			end
			CMD_SIMPLIFY: st = simplify_graph();
			CMD_CONVERT: graph_to_perm();
			CMD_READ: begin
				if (a >= nv) st = STAT_RANGE;
				else rs.result_value = rd_prm(a);
			end
			CMD_QUERY: begin
				if (a >= nv) st = STAT_RANGE;
				else begin
					p = rd_blk(a);
					rs.prev_value = p;
					rs.result_value = (p < nv) ? rd_gry(p) : END_MARK;
				end
			end
			default: ;
		endcase
		rs.node_count = 10'(nv);
		rs.status = st;
		return rs;
	endfunction

	task automatic keep_state();
		s_blk = blk; s_gry = gry; s_labs = labs; s_prm = prm;
		s_blk_w = blk_w; s_gry_w = gry_w; s_prm_w = prm_w;
		s_nv = nv; s_lpos = lpos; s_lprev = lprev;
	endtask

	task automatic back_state();
		blk = s_blk; gry = s_gry; labs = s_labs; prm = s_prm;
		blk_w = s_blk_w; gry_w = s_gry_w; prm_w = s_prm_w;
		nv = s_nv; lpos = s_lpos; lprev = s_lprev;
	endtask

	// commands that would touch never-written table entries become CMD_SPARE_6
	task automatic send(cmd_req_t rq);
		cmd_rsp_t rs;
		keep_state();
		unwritten_rd = 1'b0;
		rs = engine_step(rq);
		if (unwritten_rd) begin
			back_state();
			rq.cmd = CMD_SPARE_6;
			rs = engine_step(rq);
		end
		while ($urandom_range(0, 99) < s_idle) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
		end
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd_data <= rq;
		do @(posedge clk); while (cmd_stall);
		rsp_q.push_back(rs);
		n_items++;
	endtask

	function automatic cmd_req_t junk_req(logic [2:0] cmd);
		cmd_req_t rq;
		rq.cmd = cmd;
		rq.value = 9'($urandom);
		rq.last = 1'($urandom);
		rq.idx_a = 9'($urandom);
		rq.idx_b = 9'($urandom);
		rq.idx_c = 9'($urandom);
		return rq;
	endfunction

	task automatic send_op(logic [2:0] cmd, int unsigned a, int unsigned b, int unsigned c);
		cmd_req_t rq;
		rq = junk_req(cmd);
		rq.idx_a = 9'(a);
		rq.idx_b = 9'(b);
		rq.idx_c = 9'(c);
		send(rq);
	endtask

	task automatic load_perm(int n, bit framed);
		int p [$];
		int j, t;
		cmd_req_t rq;
		for (int i = 1; i < n; i++) p.push_back(i);
		for (int i = 0; i < p.size() - (framed ? 1 : 0); i++) begin
			j = $urandom_range(i, p.size() - 1 - (framed ? 1 : 0));
			t = p[i]; p[i] = p[j]; p[j] = t;
		end
		p.push_front(0);
		foreach (p[i]) begin
			rq = junk_req(CMD_LOAD);
			rq.value = 9'(p[i]);
			rq.last = (i == p.size() - 1);
			send(rq);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (rsp_q.size() != 0) @(posedge clk);
	endtask

	always @(negedge clk) res_stall <= ($urandom_range(0, 99) < r_idle);

	always @(posedge clk) begin
		cmd_rsp_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (rsp_q.size() == 0) report("result transfer with nothing expected");
			else begin
				want = rsp_q.pop_front();
				n_results++;
				if (want.status == STAT_RANGE) n_ranges++;
				if (want.status == STAT_CAP) n_caps++;
				if (res_data.result_value !== want.result_value)
					report($sformatf("result_value %0d, want %0d",
						res_data.result_value, want.result_value));
				if (res_data.prev_value !== want.prev_value)
					report($sformatf("prev_value %0d, want %0d",
						res_data.prev_value, want.prev_value));
				if (res_data.node_count !== want.node_count)
					report($sformatf("node_count %0d, want %0d",
						res_data.node_count, want.node_count));
				if (res_data.status !== want.status)
					report($sformatf("status %0d, want %0d",
						res_data.status, want.status));
			end
		end
	end

	task automatic test_empty_graph();
		send_op(CMD_QUERY, 0, 0, 0);
		send_op(CMD_READ, 0, 0, 0);
		send_op(CMD_TRANSPOSE, 0, 0, 0);
		send_op(CMD_SIMPLIFY, 0, 0, 0);
		send_op(CMD_CONVERT, 0, 0, 0);
		send_op(CMD_SPARE_6, 511, 511, 511);
		send_op(CMD_SPARE_7, 0, 0, 0);
	endtask

	task automatic test_small_graph();
		load_perm(5, 1'b1);
		send_op(CMD_QUERY, 0, 0, 0);
		send_op(CMD_QUERY, 4, 0, 0);
		send_op(CMD_READ, 4, 0, 0);
		send_op(CMD_TRANSPOSE, 1, 2, 3);
		send_op(CMD_TRANSPOSE, 511, 1, 1);
		send_op(CMD_TRANSPOSE, 1, 511, 1);
		send_op(CMD_TRANSPOSE, 1, 1, 511);
		send_op(CMD_QUERY, 511, 0, 0);
		send_op(CMD_READ, 5, 0, 0);
		send_op(CMD_CONVERT, 0, 0, 0);
		send_op(CMD_READ, 2, 0, 0);
		// hold off until everything is back, then the walk-heavy command
		drain();
		send_op(CMD_SIMPLIFY, 0, 0, 0);
		send_op(CMD_QUERY, 2, 0, 0);
	endtask

	task automatic test_random_sequences(int count);
		int n, ops, pick, stop;
		stop = n_items + count;
		while (n_items < stop) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise: arbitrary values, possibly not a permutation
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++) send(junk_req(CMD_LOAD));
				send_op(CMD_LOAD, 0, 0, 0);
				while (lpos != 0) begin
					cmd_req_t rq;
					rq = junk_req(CMD_LOAD);
					rq.last = 1'b1;
					send(rq);
				end
			end else begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(2, 12);
				load_perm(n, $urandom_range(0, 3) != 0);
			end
			ops = $urandom_range(3, 14);
			for (int k = 0; k < ops; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 30)
					send_op(CMD_TRANSPOSE, $urandom_range(0, nv - 1),
						$urandom_range(0, nv - 1), $urandom_range(0, nv - 1));
				else if (pick < 55) send_op(CMD_QUERY, $urandom_range(0, nv - 1), 0, 0);
				else if (pick < 70) send_op(CMD_READ, $urandom_range(0, nv - 1), 0, 0);
				else if (pick < 80) send_op(CMD_SIMPLIFY, 0, 0, 0);
				else if (pick < 88) send_op(CMD_CONVERT, 0, 0, 0);
				else if (pick < 95) send(junk_req(3'($urandom_range(1, 5))));
				else send(junk_req($urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7));
			end
		end
	endtask

	task automatic test_full_capacity();
		load_perm(CAPACITY, 1'b1);
		send_op(CMD_SIMPLIFY, 0, 0, 0);
		send_op(CMD_CONVERT, 0, 0, 0);
		send_op(CMD_READ, CAPACITY - 1, 0, 0);
		send_op(CMD_QUERY, 0, 0, 0);
	endtask

	// a load that runs past capacity never completes, so this goes last
	task automatic test_load_overrun();
		cmd_req_t rq;
		for (int i = 0; i <= CAPACITY + 1; i++) begin
			rq = junk_req(CMD_LOAD);
			rq.last = (i == CAPACITY + 1);
			send(rq);
		end
		send_op(CMD_QUERY, 3, 0, 0);
	endtask

	initial begin
		foreach (blk_w[i]) begin
			blk_w[i] = 1'b0; gry_w[i] = 1'b0; prm_w[i] = 1'b0;
			blk[i] = '0; gry[i] = '0; labs[i] = '0; prm[i] = '0;
		end
		nv = 0; lpos = 0; lprev = 0;
		errors = 0; n_items = 0; n_results = 0; n_ranges = 0; n_caps = 0;
		s_idle = 25;
		r_idle = 73;
		cmd_valid = 1'b0;
		cmd_data = '0;
		res_stall = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_graph();
		test_small_graph();
		test_random_sequences(380);
		s_idle = 73;
		r_idle = 25;
		test_random_sequences(380);
		test_full_capacity();
		s_idle = 0;
		r_idle = 0;
		test_random_sequences(100);
		test_load_overrun();
		@(negedge clk);
		cmd_valid <= 1'b0;
		drain();
		repeat (20) @(posedge clk);

		$display("ran %0d commands, %0d results checked", n_items, n_results);
		$display("%0d range errors and %0d capacity errors seen", n_ranges, n_caps);
		if (errors == 0) begin
			$display("cycle_graph_transposition_engine_top_test: PASS");
		end else begin
			$display("cycle_graph_transposition_engine_top_test: FAIL");
		end
		$finish;
	end

	initial begin
		#100000000;
		$display("cycle_graph_transposition_engine_top_test: FAIL");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/cgte_pkg.sv
rtl/cgte_ram.sv
rtl/cycle_graph_transposition_engine_top.sv
verif/cycle_graph_transposition_engine_top_test.sv
